// ----- hw/rtl/bitmap_glyph_pixel_expander_assert.svh -----
// ----------------------------------------------------------------------------
// bitmap_glyph_pixel_expander_assert.svh
// Assertion macros shared by the checker of the glyph pixel expander.
// ----------------------------------------------------------------------------
`ifndef BITMAP_GLYPH_PIXEL_EXPANDER_ASSERT_SVH
`define BITMAP_GLYPH_PIXEL_EXPANDER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BGPE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define BGPE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/bgpe_pkg.sv -----
// ----------------------------------------------------------------------------
// bgpe_pkg
// Types and fixed constants of the bitmap glyph pixel expander.
// ----------------------------------------------------------------------------
package bgpe_pkg;

	localparam int CFG_W       = 4;   // config register width
	localparam int CFG_IDX_W   = 1;   // config register index width
	localparam int ROW_ADDR_W  = 11;  // font row address field width
	localparam int ROW_W       = 8;   // font row pattern width
	localparam int SIDE_W      = 3;   // glyph row / column counter width
	localparam int RED_CNT_W   = 4;   // address reduction step counter width
	localparam int COORD_W     = 8;
	localparam int CODE_W      = 8;
	localparam int PIX_W       = 16;
	localparam int COLOR_W     = 16;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DRAW = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] CFG_SIDE_RESET = 4'd8;

	typedef struct packed {
		logic                  command;
		logic [ROW_ADDR_W-1:0] row_index;
		logic [ROW_W-1:0]      row_bits;
		logic [CODE_W-1:0]     char_code;
		logic [COORD_W-1:0]    pos_x;
		logic [COORD_W-1:0]    pos_y;
		logic [COLOR_W-1:0]    fg_color;
		logic [COLOR_W-1:0]    bg_color;
		logic                  opaque;
	} bgpe_req_t;

	typedef struct packed {
		logic [PIX_W-1:0]   pixel_index;
		logic [COLOR_W-1:0] pixel_color;
		logic               last;
	} bgpe_wr_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // write one font row
		logic start;      // latch a draw request
		logic red_step;   // one step of the row address reduction
		logic scan_step;  // evaluate one glyph pixel and advance
		logic flush;      // release the held-back pixel as the final one
	} bgpe_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;      // a configured side is zero
		logic red_last;
		logic col_last;
		logic row_last;
		logic blocked;    // current pixel cannot move for lack of space
		logic pend_valid;
		logic out_free;
	} bgpe_status_t;

endpackage

// ----- hw/rtl/bgpe_ctrl.sv -----
// ----------------------------------------------------------------------------
// bgpe_ctrl
// Sequencer of the glyph expander: idle, address reduction, scan, flush.
// ----------------------------------------------------------------------------
module bgpe_ctrl import bgpe_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	input  logic         req_command,
	output logic         req_ready,
	input  bgpe_status_t st,
	output bgpe_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_REDUCE = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;
	localparam logic [1:0] ST_FLUSH  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req_command == CMD_LOAD) begin
						cmd.load = 1'b1;
					end else if (!st.empty) begin
						cmd.start = 1'b1;
						state_d   = ST_REDUCE;
					end
				end
			end
			ST_REDUCE: begin
				cmd.red_step = 1'b1;
				if (st.red_last) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!st.blocked) begin
					cmd.scan_step = 1'b1;
					if (st.col_last && st.row_last) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				if (!st.pend_valid) begin
					state_d = ST_IDLE;
				end else if (st.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign req_ready = (state_q == ST_IDLE);

endmodule

// ----- hw/rtl/bgpe_datapath.sv -----
// ----------------------------------------------------------------------------
// bgpe_datapath
// Font store, config registers, address and pixel counters, output stage.
// ----------------------------------------------------------------------------
module bgpe_datapath import bgpe_pkg::*; #(
	parameter int FONT_DEPTH     = 2048,
	parameter int SCREEN_COLUMNS = 240,
	parameter int MAX_GLYPH_SIDE = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bgpe_cmd_t            cmd,
	output bgpe_status_t         st,
	input  bgpe_req_t            req,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 wr_valid,
	input  logic                 wr_ready,
	output bgpe_wr_t             wr
);

	localparam int AW = $clog2(FONT_DEPTH);
	localparam logic [AW-1:0]    ADDR_TOP = AW'(FONT_DEPTH - 1);
	localparam logic [PIX_W-1:0] COLS     = PIX_W'(SCREEN_COLUMNS);
	localparam logic [CFG_W-1:0] SIDE_MAX = CFG_W'(MAX_GLYPH_SIDE);
	localparam logic [RED_CNT_W-1:0] RED_LAST = RED_CNT_W'(1);
	// reciprocal of the store depth, exact for every product below 2^ROW_ADDR_W
	localparam int RED_SH  = ROW_ADDR_W + $clog2(FONT_DEPTH);
	localparam int RECIP_W = ROW_ADDR_W + 2;
	localparam int MUL_W   = ROW_ADDR_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RED_SH) +
		64'(FONT_DEPTH) - 64'd1) / 64'(FONT_DEPTH));
	localparam logic [MUL_W-1:0] DEPTH_M = MUL_W'(FONT_DEPTH);

	// configuration
	logic [CFG_W-1:0] gw_q, gh_q;
	logic [CFG_W-1:0] gw_clamp, gh_clamp;

	// latched draw
	logic [CFG_W-1:0]      w_q, h_q;
	logic [COLOR_W-1:0]    fg_q, bg_q;
	logic                  opaque_q;
	logic [PIX_W-1:0]      pos_x_q;
	logic [ROW_ADDR_W-1:0] prod_q;
	logic [ROW_ADDR_W-1:0] quo_q;
	logic [PIX_W-1:0]      line_q, col_q;
	logic [RED_CNT_W-1:0]  red_cnt_q;
	logic [SIDE_W-1:0]     j_q, i_q;
	logic [ROW_W-1:0]      row_q;

	// font store
	logic [ROW_W-1:0] font_mem [FONT_DEPTH];
	logic [ROW_W-1:0] rd_q;
	logic [AW-1:0]    addr_q, addr_d, addr_red, addr_inc;
	logic [MUL_W-1:0] recip_prod, quo_mul, red_rem;
	logic             load_ok;

	// pixel path
	logic [ROW_W-1:0]   src;
	logic [CFG_W-1:0]   bit_idx;
	logic               pix_bit, emit;
	logic [COLOR_W-1:0] pix_color;
	logic               pend_valid_q;
	logic [PIX_W-1:0]   pend_idx_q;
	logic [COLOR_W-1:0] pend_color_q;
	logic               out_valid_q;
	bgpe_wr_t           out_q;
	logic               out_free, push_mid;

	assign gw_clamp = (gw_q > SIDE_MAX) ? SIDE_MAX : gw_q;
	assign gh_clamp = (gh_q > SIDE_MAX) ? SIDE_MAX : gh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q <= CFG_SIDE_RESET;
			gh_q <= CFG_SIDE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_GLYPH_WIDTH) begin
				gw_q <= cfg_data;
			end else begin
				gh_q <= cfg_data;
			end
		end
	end

	// row address: h*code mod store depth; quotient on the first step,
	// remainder on the second
	assign recip_prod = MUL_W'(prod_q) * MUL_W'(RECIP);
	assign quo_mul    = MUL_W'(quo_q) * DEPTH_M;
	assign red_rem    = MUL_W'(prod_q) - quo_mul;
	assign addr_red   = AW'(red_rem);
	assign addr_inc   = (addr_q == ADDR_TOP) ? '0 : addr_q + AW'(1);

	always_comb begin
		addr_d = addr_q;
		if (cmd.start) begin
			addr_d = '0;
		end else if (cmd.red_step && st.red_last) begin
			addr_d = addr_red;
		end else if (cmd.scan_step && (j_q == '0)) begin
			addr_d = addr_inc;
		end
	end

	assign load_ok = (32'(req.row_index) < 32'(FONT_DEPTH));

	// read data always follows addr_q
	always_ff @(posedge clk) begin
		if (cmd.load && load_ok) begin
			font_mem[AW'(req.row_index)] <= req.row_bits;
		end
		rd_q <= font_mem[addr_d];
	end

	// pixel evaluation
	assign src       = (j_q == '0) ? rd_q : row_q;
	assign bit_idx   = w_q - CFG_W'(1) - CFG_W'(j_q);
	assign pix_bit   = src[bit_idx[SIDE_W-1:0]];
	assign emit      = pix_bit || opaque_q;
	assign pix_color = pix_bit ? fg_q : bg_q;
	assign out_free  = !out_valid_q || wr_ready;
	assign push_mid  = cmd.scan_step && emit && pend_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q    <= '0;
			red_cnt_q <= '0;
			j_q       <= '0;
			i_q       <= '0;
		end else begin
			addr_q <= addr_d;
			if (cmd.start) begin
				red_cnt_q <= '0;
				j_q       <= '0;
				i_q       <= '0;
			end else if (cmd.red_step) begin
				red_cnt_q <= red_cnt_q + RED_CNT_W'(1);
			end else if (cmd.scan_step) begin
				if (st.col_last) begin
					j_q <= '0;
					i_q <= i_q + SIDE_W'(1);
				end else begin
					j_q <= j_q + SIDE_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			w_q      <= gw_clamp;
			h_q      <= gh_clamp;
			fg_q     <= req.fg_color;
			bg_q     <= req.bg_color;
			opaque_q <= req.opaque;
			pos_x_q  <= PIX_W'(req.pos_x);
			prod_q   <= ROW_ADDR_W'(gh_clamp) * ROW_ADDR_W'(req.char_code);
			line_q   <= PIX_W'(req.pos_y) * COLS;
		end else if (cmd.red_step) begin
			quo_q <= ROW_ADDR_W'(recip_prod >> RED_SH);
			col_q <= line_q + pos_x_q;
		end else if (cmd.scan_step) begin
			if (j_q == '0) begin
				row_q <= rd_q;
			end
			if (st.col_last) begin
				line_q <= line_q + COLS;
				col_q  <= line_q + COLS + pos_x_q;
			end else begin
				col_q <= col_q + PIX_W'(1);
			end
		end
	end

	// hold-back stage: a pixel is released once the next one or the end is known
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.scan_step && emit) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if (push_mid || cmd.flush) begin
				out_valid_q <= 1'b1;
			end else if (wr_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && emit) begin
			pend_idx_q   <= col_q;
			pend_color_q <= pix_color;
		end
		if (push_mid || cmd.flush) begin
			out_q.pixel_index <= pend_idx_q;
			out_q.pixel_color <= pend_color_q;
			out_q.last        <= cmd.flush;
		end
	end

	assign wr_valid = out_valid_q;
	assign wr       = out_q;

	assign st.empty      = (gw_clamp == '0) || (gh_clamp == '0);
	assign st.red_last   = (red_cnt_q == RED_LAST);
	assign st.col_last   = (CFG_W'(j_q) == w_q - CFG_W'(1));
	assign st.row_last   = (CFG_W'(i_q) == h_q - CFG_W'(1));
	assign st.blocked    = emit && pend_valid_q && !out_free;
	assign st.pend_valid = pend_valid_q;
	assign st.out_free   = out_free;

endmodule

// ----- hw/rtl/bitmap_glyph_pixel_expander.sv -----
// ----------------------------------------------------------------------------
// bitmap_glyph_pixel_expander
// Bitmap font character generator: loads glyph rows into a font store and
// expands a glyph into one framebuffer write per drawn pixel.
// ----------------------------------------------------------------------------
//
//  channel | signals                        | moves
//  --------+--------------------------------+-------------------------------
//  req     | req_valid, req_ready, req      | load row / draw glyph request
//  wr      | wr_valid, wr_ready, wr         | framebuffer write, last flagged
//  cfg     | cfg_we, cfg_index, cfg_data    | glyph_width / glyph_height
//
// A draw is accepted while idle, then the font address h*code modulo
// FONT_DEPTH is reduced (reciprocal multiply, then subtract), then the scan
// takes one glyph pixel per cycle unless stalled (w*h, 64 for 8x8; skipped
// pixels too), then a flush step ends the draw. A side of zero draws nothing
// and the block stays idle. Back-pressure on wr stalls the scan
// only when a pixel must move and both held pixel and output register are
// full, and holds the flush until the output register frees up.
// Reset clears the controller and the output stage; the font store is not
// cleared.
//
module bitmap_glyph_pixel_expander import bgpe_pkg::*; #(
	parameter int FONT_DEPTH     = 2048,
	parameter int SCREEN_COLUMNS = 240,
	parameter int MAX_GLYPH_SIDE = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  bgpe_req_t            req,
	output logic                 wr_valid,
	input  logic                 wr_ready,
	output bgpe_wr_t             wr,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	bgpe_cmd_t    cmd;
	bgpe_status_t st;

	// sequencer: one request at a time, ready only when idle
	bgpe_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_command (req.command),
		.req_ready   (req_ready),
		.st          (st),
		.cmd         (cmd)
	);

	// font store, counters and the output register
	bgpe_datapath #(
		.FONT_DEPTH     (FONT_DEPTH),
		.SCREEN_COLUMNS (SCREEN_COLUMNS),
		.MAX_GLYPH_SIDE (MAX_GLYPH_SIDE)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.wr_valid  (wr_valid),
		.wr_ready  (wr_ready),
		.wr        (wr)
	);

endmodule

// ----- hw/rtl/bgpe_checker.sv -----
// ----------------------------------------------------------------------------
// bgpe_checker
// Port-level checks of the glyph pixel expander, bound to the top level.
// ----------------------------------------------------------------------------
`include "bitmap_glyph_pixel_expander_assert.svh"

module bgpe_checker import bgpe_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_ready,
	input bgpe_req_t            req,
	input logic                 wr_valid,
	input logic                 wr_ready,
	input bgpe_wr_t             wr,
	input logic                 cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0]     cfg_data
);

	logic               w_zero_q, h_zero_q;
	logic [COLOR_W-1:0] fg_q, bg_q;
	logic               opaque_q;
	logic               draw_go;

	assign draw_go = req_valid && req_ready && (req.command == CMD_DRAW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_zero_q <= 1'b0;
			h_zero_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_GLYPH_WIDTH) begin
				w_zero_q <= (cfg_data == '0);
			end else begin
				h_zero_q <= (cfg_data == '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (draw_go) begin
			fg_q     <= req.fg_color;
			bg_q     <= req.bg_color;
			opaque_q <= req.opaque;
		end
	end

	`BGPE_ASSERT_NXT(a_wr_hold, clk, arst_n, wr_valid && !wr_ready, wr_valid && $stable(wr), "stalled write changed")
	`BGPE_ASSERT_NXT(a_draw_busy, clk, arst_n, draw_go && !w_zero_q && !h_zero_q, !req_ready, "request taken during a draw")
	`BGPE_ASSERT_IMP(a_mid_busy, clk, arst_n, wr_valid && !wr.last, !req_ready, "idle with a glyph unfinished")
	`BGPE_ASSERT_IMP(a_color, clk, arst_n, wr_valid && !wr.last, (wr.pixel_color == fg_q) || (opaque_q && (wr.pixel_color == bg_q)), "pixel color not from the draw")

endmodule

bind bitmap_glyph_pixel_expander bgpe_checker u_bgpe_checker (.*);

// ----- dv/bitmap_glyph_pixel_expander_tb.sv -----
// ----------------------------------------------------------------------------
// bitmap_glyph_pixel_expander_tb
// Self-checking bench for the glyph pixel expander. Font rows are loaded and
// glyphs are drawn under several width/height settings. Every framebuffer
// write is checked in order against a local model of the font store and the
// pixel scan. Both handshakes are throttled at random, and one long output
// hold backs the block up into its request side.
// ----------------------------------------------------------------------------
module bitmap_glyph_pixel_expander_tb import bgpe_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FONT_ROWS    = 2048;
	localparam int FONT_AW      = $clog2(FONT_ROWS);
	localparam int SCREEN_COLS  = 240;
	localparam int MAX_SIDE     = 8;
	localparam int RESET_CYCLES = 10;
	// give a draw with no writes time to finish
	localparam int IDLE_CYCLES  = 100;
	localparam int RANDOM_REQS  = 320;
	localparam int HOLD_CYCLES  = 400;
	// watchdog limit above the slowest legal run
	localparam longint TIMEOUT_NS = 10_000_000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	bgpe_req_t            req = '0;
	logic                 wr_valid;
	logic                 wr_ready = 1'b0;
	bgpe_wr_t             wr;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// local copy of the block state
	logic [ROW_W-1:0] font_shadow [FONT_ROWS];
	bit               row_loaded [FONT_ROWS];
	logic [CFG_W-1:0] glyph_w = CFG_SIDE_RESET;
	logic [CFG_W-1:0] glyph_h = CFG_SIDE_RESET;

	// framebuffer writes still owed by the block, oldest first
	bgpe_wr_t pixel_writes_q [$];

	int unsigned n_fail = 0;
	int unsigned reqs_sent = 0;

	// sender throttling
	bit          send_gaps = 1'b0;
	int unsigned burst_left = 0;

	// receiver throttling
	bit          sink_stalls = 1'b0;
	int unsigned sink_hold_cycles = 0;

	bitmap_glyph_pixel_expander #(
		.FONT_DEPTH     (FONT_ROWS),
		.SCREEN_COLUMNS (SCREEN_COLS),
		.MAX_GLYPH_SIDE (MAX_SIDE)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.wr_valid  (wr_valid),
		.wr_ready  (wr_ready),
		.wr        (wr),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------------
	// model
	// ------------------------------------------------------------------------

	// sides above the maximum act as the maximum; zero stays zero
	function automatic int unsigned side_limit(input logic [CFG_W-1:0] v);
		return (v > MAX_SIDE) ? MAX_SIDE : int'(v);
	endfunction

	// Update the font shadow for a load, or expand a draw into the writes it
	// owes: rows top to bottom, pixels left to right, MSB of the used width
	// first. Transparent draws drop clear pixels; last goes on the final one.
	function automatic void apply_request(input bgpe_req_t r);
		int unsigned w;
		int unsigned h;
		int unsigned addr;
		int unsigned line;
		logic [ROW_W-1:0] bits;
		logic px_on;
		bgpe_wr_t pw;
		bgpe_wr_t glyph_q [$];

		if (r.command == CMD_LOAD) begin
			if (r.row_index < FONT_ROWS) begin
				font_shadow[r.row_index] = r.row_bits;
				row_loaded[r.row_index] = 1'b1;
			end
			return;
		end
		w = side_limit(glyph_w);
		h = side_limit(glyph_h);
		for (int unsigned i = 0; i < h; i++) begin
			addr = (h * r.char_code + i) % FONT_ROWS;
			bits = font_shadow[addr[FONT_AW-1:0]];
			line = ((r.pos_y + i) * SCREEN_COLS) & 32'hFFFF;
			for (int unsigned j = 0; j < w; j++) begin
				px_on = bits[SIDE_W'(w - 1 - j)];
				if (!px_on && !r.opaque) begin
					continue;
				end
				pw.pixel_index = PIX_W'(line + r.pos_x + j);
				pw.pixel_color = px_on ? r.fg_color : r.bg_color;
				pw.last = 1'b0;
				glyph_q.push_back(pw);
			end
		end
		foreach (glyph_q[k]) begin
			pw = glyph_q[k];
			pw.last = (k == glyph_q.size() - 1);
			pixel_writes_q.push_back(pw);
		end
	endfunction

	// ------------------------------------------------------------------------
	// output side
	// ------------------------------------------------------------------------

	// Ready pattern: free-running, random short stalls, or one long hold
	// requested by a test and counted here.
	initial begin : wr_sink
		int unsigned n;

		forever begin
			if (sink_hold_cycles > 0) begin
				n = sink_hold_cycles;
				sink_hold_cycles = 0;
				wr_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (sink_stalls) begin
				wr_ready <= 1'b1;
				repeat ($urandom_range(12, 1)) @(posedge clk);
				wr_ready <= 1'b0;
				repeat ($urandom_range(4, 1)) @(posedge clk);
			end else begin
				wr_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Every wr transfer is matched against the oldest owed write.
	always @(posedge clk) begin : wr_check
		bgpe_wr_t want;

		if (arst_n && wr_valid && wr_ready) begin
			if (pixel_writes_q.size() == 0) begin
				$error("unexpected write: pixel_index %0d pixel_color %0h last %0b",
					wr.pixel_index, wr.pixel_color, wr.last);
				n_fail++;
			end else begin
				want = pixel_writes_q.pop_front();
				if (wr.pixel_index !== want.pixel_index) begin
					$error("pixel_index: expected %0d, actual %0d",
						want.pixel_index, wr.pixel_index);
					n_fail++;
				end
				if (wr.pixel_color !== want.pixel_color) begin
					$error("pixel_color: expected %0h, actual %0h",
						want.pixel_color, wr.pixel_color);
					n_fail++;
				end
				if (wr.last !== want.last) begin
					$error("last: expected %0b, actual %0b", want.last, wr.last);
					n_fail++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------------

	// Offer one request and hold it until the transfer. With gaps on, requests
	// go out in bursts of random length separated by idle stretches.
	task automatic offer_request(input bgpe_req_t item);
		if (send_gaps && burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(8, 1)) @(posedge clk);
			burst_left = $urandom_range(16, 1);
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		apply_request(item);
		reqs_sent++;
	endtask

	// all fields random; unused fields of either command carry noise
	function automatic bgpe_req_t noise_request();
		bgpe_req_t r;

		r.command   = 1'($urandom_range(1, 0));
		r.row_index = ROW_ADDR_W'($urandom);
		r.row_bits  = ROW_W'($urandom);
		r.char_code = CODE_W'($urandom);
		r.pos_x     = COORD_W'($urandom);
		r.pos_y     = COORD_W'($urandom);
		r.fg_color  = COLOR_W'($urandom);
		r.bg_color  = COLOR_W'($urandom);
		r.opaque    = 1'($urandom_range(1, 0));
		return r;
	endfunction

	// blank and solid rows show up often so clear-only glyphs occur
	function automatic logic [ROW_W-1:0] random_row_bits();
		case ($urandom_range(7, 0))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			default: begin
				return ROW_W'($urandom);
			end
		endcase
	endfunction

	task automatic load_row(input int unsigned addr, input logic [ROW_W-1:0] bits);
		bgpe_req_t r;

		r = noise_request();
		r.command = CMD_LOAD;
		r.row_index = ROW_ADDR_W'(addr);
		r.row_bits = bits;
		offer_request(r);
	endtask

	// Draw one glyph, first loading any of its rows that were never written:
	// reading an unwritten row is outside the block's contract.
	task automatic draw_glyph(input logic [CODE_W-1:0] code,
		input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
		input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg,
		input logic opq);
		bgpe_req_t r;
		int unsigned h;
		int unsigned addr;

		h = side_limit(glyph_h);
		for (int unsigned i = 0; i < h; i++) begin
			addr = (h * code + i) % FONT_ROWS;
			if (!row_loaded[addr[FONT_AW-1:0]]) begin
				load_row(addr, random_row_bits());
			end
		end
		r = noise_request();
		r.command = CMD_DRAW;
		r.char_code = code;
		r.pos_x = x;
		r.pos_y = y;
		r.fg_color = fg;
		r.bg_color = bg;
		r.opaque = opq;
		offer_request(r);
	endtask

	// Drop valid, wait for every owed write, then let a draw that owes
	// nothing run out before the registers may change.
	task automatic settle_block();
		req_valid <= 1'b0;
		while (pixel_writes_q.size() != 0) @(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	// both registers, one per cycle; only called with the block idle
	task automatic set_glyph_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		cfg_we <= 1'b1;
		cfg_index <= REG_GLYPH_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		glyph_w = w;
		cfg_index <= REG_GLYPH_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		glyph_h = h;
		cfg_we <= 1'b0;
	endtask

	function automatic logic [CFG_W-1:0] random_side();
		case ($urandom_range(19, 0))
			0: begin
				return '0;
			end
			1: begin
				return CFG_W'($urandom_range(15, MAX_SIDE + 1));
			end
			default: begin
				return CFG_W'($urandom_range(MAX_SIDE, 1));
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// 8x8 glyphs: edge patterns, top and bottom of the font store, coordinate
	// extremes, both modes, color extremes
	task automatic test_directed_glyphs();
		logic [ROW_W-1:0] pat [8] = '{8'hFF, 8'h00, 8'h80, 8'h01,
			8'hAA, 8'h55, 8'hF0, 8'h0F};

		set_glyph_size(4'd8, 4'd8);
		for (int unsigned i = 0; i < 8; i++) begin
			load_row(i, pat[SIDE_W'(i)]);
		end
		draw_glyph(8'd0, 8'd0, 8'd0, 16'hFFFF, 16'h0000, 1'b1);
		draw_glyph(8'd0, 8'd255, 8'd255, 16'h0000, 16'hFFFF, 1'b0);
		// char 255 sits in the last eight rows of the store
		draw_glyph(8'd255, 8'd128, 8'd7, 16'h1234, 16'hEDCB, 1'b1);
	endtask

	// one-pixel glyphs, zero sides, oversized sides
	task automatic test_side_extremes();
		settle_block();
		set_glyph_size(4'd1, 4'd1);
		// char 1 is the blank row: transparent draw owes nothing
		draw_glyph(8'd1, 8'd10, 8'd20, 16'hFFFF, 16'h0000, 1'b0);
		draw_glyph(8'd1, 8'd10, 8'd20, 16'hFFFF, 16'h0000, 1'b1);
		draw_glyph(8'd0, 8'd255, 8'd0, 16'hA5A5, 16'h5A5A, 1'b0);

		settle_block();
		set_glyph_size(4'd0, 4'd8);
		draw_glyph(8'd0, 8'd1, 8'd1, 16'hFFFF, 16'hFFFF, 1'b1);

		settle_block();
		set_glyph_size(4'd8, 4'd0);
		draw_glyph(8'd0, 8'd1, 8'd1, 16'hFFFF, 16'hFFFF, 1'b1);

		// 15 saturates to 8 on both sides
		settle_block();
		set_glyph_size(4'd15, 4'd15);
		draw_glyph(8'd0, 8'd3, 8'd250, 16'h00FF, 16'hFF00, 1'b1);
	endtask

	// Output held off for a long stretch while full opaque glyphs keep
	// coming: the scan stalls and req_ready has to drop.
	task automatic test_output_backpressure();
		settle_block();
		set_glyph_size(4'd8, 4'd8);
		send_gaps = 1'b0;
		sink_stalls = 1'b1;
		sink_hold_cycles = HOLD_CYCLES;
		repeat (6) begin
			draw_glyph(CODE_W'($urandom_range(3, 0)), COORD_W'($urandom),
				COORD_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom), 1'b1);
		end
	endtask

	// Phases of random traffic, each under its own glyph size and throttling.
	// Mostly draws (rows loaded on demand); the rest are loads to arbitrary
	// rows that may overwrite glyphs already in use.
	task automatic test_random_traffic(input int unsigned n_reqs);
		int unsigned stop_at;
		int unsigned phase_end;
		logic [CODE_W-1:0] code;

		stop_at = reqs_sent + n_reqs;
		while (reqs_sent < stop_at) begin
			settle_block();
			set_glyph_size(random_side(), random_side());
			send_gaps = ($urandom_range(3, 0) != 0);
			sink_stalls = ($urandom_range(3, 0) != 0);
			burst_left = 0;
			phase_end = reqs_sent + $urandom_range(45, 20);
			while (reqs_sent < phase_end && reqs_sent < stop_at) begin
				if ($urandom_range(6, 0) == 0) begin
					load_row($urandom_range(FONT_ROWS - 1, 0), random_row_bits());
				end else begin
					// a small set of codes gets reused, the rest spread wide
					code = ($urandom_range(1, 0) != 0) ?
						CODE_W'($urandom_range(15, 0)) : CODE_W'($urandom);
					draw_glyph(code, COORD_W'($urandom), COORD_W'($urandom),
						COLOR_W'($urandom), COLOR_W'($urandom),
						1'($urandom_range(1, 0)));
				end
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------

	initial begin : run_tests
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_glyphs();
		test_side_extremes();
		test_output_backpressure();
		test_random_traffic(RANDOM_REQS);

		settle_block();
		if (n_fail == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/bgpe_pkg.sv
hw/rtl/bgpe_ctrl.sv
hw/rtl/bgpe_datapath.sv
hw/rtl/bitmap_glyph_pixel_expander.sv
hw/rtl/bgpe_checker.sv
dv/bitmap_glyph_pixel_expander_tb.sv
